// File: rtl/apt_pkg.sv
`timescale 1ns / 1ps

package apt_pkg;

    // Field widths of a request and a response.
    localparam int IP_W  = 32;
    localparam int MAC_W = 48;

    // Request kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Response status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // One slot of the table as it sits in the RAM.
    typedef struct packed {
        logic             valid;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/apt_ram.sv
`timescale 1ns / 1ps

module apt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/apt_mod.sv
`timescale 1ns / 1ps

module apt_mod #(
    parameter int DIVISOR = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [apt_pkg::IP_W-1:0]   dividend,
    output logic                       done,
    output logic [$clog2(DIVISOR)-1:0] remainder
);

    localparam int IP_W   = apt_pkg::IP_W;
    localparam int REM_W  = $clog2(DIVISOR);
    localparam int PROD_W = 2 * IP_W;
    // Reciprocal of the divisor scaled by 2^32, rounded down.
    localparam logic [IP_W-1:0] RECIP = IP_W'((64'd1 << IP_W) / DIVISOR);
    localparam logic [IP_W-1:0] DIV_M = IP_W'(DIVISOR);
    localparam logic [REM_W:0]  DIV_C = (REM_W + 1)'(DIVISOR);

    // Multiplier phases.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_RECIP = 2'd1;
    localparam logic [1:0] PH_BACK  = 2'd2;
    localparam logic [1:0] PH_FIX   = 2'd3;

    logic [1:0]        phase_reg, phase_next;
    logic              done_reg, done_next;
    logic [IP_W-1:0]   dvd_reg, dvd_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [IP_W-1:0]   mul_a;
    logic [IP_W-1:0]   mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [IP_W-1:0]   diff;
    logic [REM_W:0]    rem_est;
    logic [REM_W:0]    rem_sub;

    // Shared multiplier: first the dividend times the reciprocal, then the quotient
    // estimate times the divisor.
    assign mul_a = (phase_reg == PH_BACK) ? prod_reg[PROD_W-1:IP_W] : dvd_reg;
    assign mul_b = (phase_reg == PH_BACK) ? DIV_M : RECIP;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // The quotient estimate is low by at most one, so the remainder estimate stays
    // below twice the divisor and one conditional subtract finishes it.
    assign diff    = dvd_reg - prod_reg[IP_W-1:0];
    assign rem_est = diff[REM_W:0];
    assign rem_sub = rem_est - DIV_C;

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        dvd_next   = dvd_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            phase_next = PH_RECIP;
            dvd_next   = dividend;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    // Nothing to do until the next start.
                end
                PH_RECIP:
                begin
                    prod_next  = mul_p;
                    phase_next = PH_BACK;
                end
                PH_BACK:
                begin
                    prod_next  = mul_p;
                    phase_next = PH_FIX;
                end
                PH_FIX:
                begin
                    rem_next   = (rem_est >= DIV_C) ? rem_sub[REM_W-1:0] : rem_est[REM_W-1:0];
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/arp_cache_probe_table.sv
// Home slot: formed by a reciprocal multiply, a multiply back and a conditional subtract
// on one shared multiplier; then one slot is probed per cycle through the table RAM's
// read port. Requests: one at a time; a new one is not taken until the probe loop ends
// and the response is handed over, which waits while rsp_stall holds the previous response.
// Reset: rst_n is asynchronous; a clearing pass then writes every slot with req_stall high.
`timescale 1ns / 1ps

module arp_cache_probe_table #(
    parameter int ENTRIES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic                        kind,
    input  logic [apt_pkg::IP_W-1:0]    ip_addr,
    input  logic [apt_pkg::MAC_W-1:0]   mac_in,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic                        status,
    output logic [apt_pkg::MAC_W-1:0]   mac_out
);

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0]  ALL_SLOTS  = CNT_W'(ENTRIES);
    localparam logic [CNT_W-1:0]  LAST_CHECK = CNT_W'(ENTRIES - 1);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [SLOT_W-1:0]           slot_reg, slot_next;
    logic [CNT_W-1:0]            issue_cnt_reg, issue_cnt_next;
    logic [CNT_W-1:0]            chk_cnt_reg, chk_cnt_next;
    logic                        chk_valid_reg, chk_valid_next;
    logic [SLOT_W-1:0]           chk_slot_reg, chk_slot_next;
    logic                        kind_reg, kind_next;
    logic [apt_pkg::IP_W-1:0]    ip_reg, ip_next;
    logic [apt_pkg::MAC_W-1:0]   mac_reg, mac_next;
    logic                        res_status_reg, res_status_next;
    logic [apt_pkg::MAC_W-1:0]   res_mac_reg, res_mac_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_status_reg, out_status_next;
    logic [apt_pkg::MAC_W-1:0]   out_mac_reg, out_mac_next;

    logic                        mod_start;
    logic                        mod_done;
    logic [SLOT_W-1:0]           mod_rem;

    logic                        ram_we;
    logic [SLOT_W-1:0]           ram_waddr;
    apt_pkg::entry_t             ram_wentry;
    logic [apt_pkg::ENTRY_W-1:0] ram_rdata;
    apt_pkg::entry_t             rd_entry;

    logic                        ip_eq;
    logic                        hit;
    logic [SLOT_W-1:0]           slot_wrap;

    // Home slot: the address modulo the table size.
    apt_mod #(
        .DIVISOR (ENTRIES)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (ip_addr),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Table storage; the read address is the slot being probed.
    apt_ram #(
        .WIDTH (apt_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry  = apt_pkg::entry_t'(ram_rdata);
    assign slot_wrap = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    // An insert stops at an empty slot or its own address; a lookup only at a valid match.
    assign ip_eq = (rd_entry.ip == ip_reg);
    assign hit   = (kind_reg == apt_pkg::KIND_INSERT) ? (!rd_entry.valid || ip_eq)
                                                      : (rd_entry.valid && ip_eq);

    // Sequencer: clear, take a request, hash, probe, hand over the response.
    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        issue_cnt_next  = issue_cnt_reg;
        chk_cnt_next    = chk_cnt_reg;
        chk_valid_next  = 1'b0;
        chk_slot_next   = chk_slot_reg;
        kind_next       = kind_reg;
        ip_next         = ip_reg;
        mac_next        = mac_reg;
        res_status_next = res_status_reg;
        res_mac_next    = res_mac_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_status_next = out_status_reg;
        out_mac_next    = out_mac_reg;
        mod_start       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = chk_slot_reg;
        ram_wentry      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot_reg;
                if (slot_reg == LAST_SLOT)
                begin
                    slot_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = kind;
                    ip_next    = ip_addr;
                    mac_next   = mac_in;
                    mod_start  = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (mod_done)
                begin
                    slot_next      = mod_rem;
                    issue_cnt_next = '0;
                    chk_cnt_next   = '0;
                    state_next     = S_PROBE;
                end
            end
            S_PROBE:
            begin
                // Issue the next slot's read while the previous slot is checked.
                if (issue_cnt_reg != ALL_SLOTS)
                begin
                    slot_next      = slot_wrap;
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_slot_next  = slot_reg;
                end
                if (chk_valid_reg)
                begin
                    chk_cnt_next = chk_cnt_reg + 1'b1;
                    if (hit)
                    begin
                        if (kind_reg == apt_pkg::KIND_INSERT)
                        begin
                            ram_we           = 1'b1;
                            ram_wentry.valid = 1'b1;
                            ram_wentry.ip    = ip_reg;
                            ram_wentry.mac   = mac_reg;
                            res_mac_next     = '0;
                        end
                        else
                        begin
                            res_mac_next = rd_entry.mac;
                        end
                        res_status_next = apt_pkg::STATUS_OK;
                        chk_valid_next  = 1'b0;
                        state_next      = S_DONE;
                    end
                    else if (chk_cnt_reg == LAST_CHECK)
                    begin
                        // Every slot visited: full table on insert, miss on lookup.
                        res_status_next = apt_pkg::STATUS_FAIL;
                        res_mac_next    = '0;
                        chk_valid_next  = 1'b0;
                        state_next      = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_mac_next    = res_mac_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            slot_reg      <= '0;
            issue_cnt_reg <= '0;
            chk_cnt_reg   <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            issue_cnt_reg <= issue_cnt_next;
            chk_cnt_reg   <= chk_cnt_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and response payload registers.
    always_ff @(posedge clk)
    begin
        chk_slot_reg   <= chk_slot_next;
        kind_reg       <= kind_next;
        ip_reg         <= ip_next;
        mac_reg        <= mac_next;
        res_status_reg <= res_status_next;
        res_mac_reg    <= res_mac_next;
        out_status_reg <= out_status_next;
        out_mac_reg    <= out_mac_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign mac_out   = out_mac_reg;

endmodule

// File: rtl/apt_checker.sv
`timescale 1ns / 1ps

module apt_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic                      req_stall,
    input  logic                      kind,
    input  logic [apt_pkg::IP_W-1:0]  ip_addr,
    input  logic [apt_pkg::MAC_W-1:0] mac_in,
    input  logic                      rsp_valid,
    input  logic                      rsp_stall,
    input  logic                      status,
    input  logic [apt_pkg::MAC_W-1:0] mac_out
);

    // A stalled request keeps its payload until it is taken.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(kind) && $stable(ip_addr)
                                   && $stable(mac_in))
        else $error("request changed while stalled");

    // A held response keeps its payload until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(mac_out))
        else $error("response changed while stalled");

    // A failed request never reports a MAC.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == apt_pkg::STATUS_FAIL) |-> (mac_out == '0))
        else $error("failed request carries a MAC");

    // After a request is taken the block stays busy while it hashes the address.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall ##1 req_stall)
        else $error("request port reopened during hashing");

endmodule

bind arp_cache_probe_table apt_checker u_apt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .kind      (kind),
    .ip_addr   (ip_addr),
    .mac_in    (mac_in),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .mac_out   (mac_out)
);
